/* rtl/hashed_trie_edge_map_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the edge map core
// Small wrappers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HASHED_TRIE_EDGE_MAP_CORE_MACROS_SVH
`define HASHED_TRIE_EDGE_MAP_CORE_MACROS_SVH

// Implication that must hold on every rising clock edge outside reset.
`define HTEM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HTEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/htem_pkg.sv */
// ----------------------------------------------------------------------------
// Edge map package
// Shared types, codes and defaults of the hashed trie edge map.
// ----------------------------------------------------------------------------
package htem_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int BUCKETS_DEF   = 1364;
    localparam logic [15:0] ALPHABET_RESET = 16'd256;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_CREATE = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_CREATED  = 3'd1;
    localparam logic [2:0] ST_ABSENT   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DELETED  = 3'd4;
    localparam logic [2:0] ST_DEL_NONE = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_MOD, S_HEAD, S_READ, S_CHECK,
        S_UNLINK, S_POP, S_WRITE, S_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the input item
        logic hash;      // form parent*alphabet+symbol
        logic modstep;   // one reduction step of the hash
        logic head_rd;   // read the bucket head
        logic rec_rd;    // read the record at cur
        logic advance;   // move to the next record
        logic unlink;    // unlink the hit record
        logic pop_rd;    // read top of freed stack
        logic create;    // write new record and head
        logic clr_wr;    // clearing pass write
        logic res_load;  // load the result register
        logic [2:0] res_status;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [1:0] action;
        logic mod_done;
        logic cur_zero;
        logic match;
        logic walk_over;
        logic free_empty;
        logic fresh_out;
        logic clr_last;
    } sts_t;

endpackage

/* rtl/htem_ctrl.sv */
// ----------------------------------------------------------------------------
// Edge map controller
// Sequences hashing, chain walk, create and delete over the datapath.
// ----------------------------------------------------------------------------
module htem_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           res_busy,
    input  htem_pkg::sts_t sts,
    output htem_pkg::cmd_t cmd
);
    import htem_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_CLEAR;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                in_ready = !res_busy;
                if (in_valid && !res_busy) begin
                    cmd.load = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                cmd.hash = 1'b1;
                state_next = S_MOD;
            end
            S_MOD: begin
                cmd.modstep = 1'b1;
                if (sts.mod_done) state_next = S_HEAD;
            end
            S_HEAD: begin
                cmd.head_rd = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                if (sts.cur_zero || sts.walk_over) begin
                    state_next = S_DONE;
                    cmd.res_load = 1'b1;
                    if (sts.action == ACT_DELETE) begin
                        cmd.res_status = ST_DEL_NONE;
                    end else if (sts.action != ACT_CREATE) begin
                        cmd.res_status = ST_ABSENT;
                    end else if (sts.free_empty && sts.fresh_out) begin
                        cmd.res_status = ST_FULL;
                    end else begin
                        cmd.res_load = 1'b0;
                        cmd.pop_rd = 1'b1;
                        state_next = S_POP;
                    end
                end else begin
                    cmd.rec_rd = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.match) begin
                    if (sts.action == ACT_DELETE) begin
                        state_next = S_UNLINK;
                    end else begin
                        cmd.res_load = 1'b1;
                        cmd.res_status = ST_FOUND;
                        state_next = S_DONE;
                    end
                end else begin
                    cmd.advance = 1'b1;
                    state_next = S_READ;
                end
            end
            S_UNLINK: begin
                cmd.unlink = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_status = ST_DELETED;
                state_next = S_DONE;
            end
            S_POP: state_next = S_WRITE;
            S_WRITE: begin
                cmd.create = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_status = ST_CREATED;
                state_next = S_DONE;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* rtl/htem_dp.sv */
// ----------------------------------------------------------------------------
// Edge map datapath
// Hash unit, bucket and record memories, freed stack and result register.
// ----------------------------------------------------------------------------
module htem_dp #(
    parameter int MAX_NODES = htem_pkg::MAX_NODES_DEF,
    parameter int BUCKETS   = htem_pkg::BUCKETS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [15:0]    alphabet,
    input  logic [1:0]     in_action,
    input  logic [9:0]     in_parent,
    input  logic [15:0]    in_symbol,
    input  htem_pkg::cmd_t cmd,
    output htem_pkg::sts_t sts,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [9:0]     res_child,
    output logic [2:0]     res_status
);
    import htem_pkg::*;

    localparam int IW = $clog2(MAX_NODES + 1);
    localparam int NW = $clog2(MAX_NODES);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int HW = 26;
    localparam int RECIP = (1 << HW) / BUCKETS;
    localparam int RW = $clog2(RECIP + 1);
    localparam logic [RW-1:0] RECIP_W = RW'(RECIP);
    localparam logic [HW-1:0] BUCK_H  = HW'(BUCKETS);

    logic [IW-1:0] head_mem [BUCKETS];
    logic [9:0]    par_mem  [MAX_NODES];
    logic [15:0]   sym_mem  [MAX_NODES];
    logic [IW-1:0] link_mem [MAX_NODES];
    logic [IW-1:0] free_mem [MAX_NODES];

    logic [1:0]    act_reg;
    logic [9:0]    par_reg;
    logic [15:0]   sym_reg;
    logic [HW-1:0] hash_reg;
    logic [1:0]    mstep_reg;
    logic [RW-1:0] quot_reg;
    logic [IW-1:0] cur_reg, prev_reg, head_q, next_q, top_q;
    logic [9:0]    rpar_q;
    logic [15:0]   rsym_q;
    logic          cur_from_head_reg;
    logic [IW:0]   steps_reg;
    logic [IW-1:0] freed_cnt_reg, fresh_reg;
    logic [BW-1:0] clr_reg;
    logic          rv_reg;
    logic [9:0]    rc_reg;
    logic [2:0]    rs_reg;
    logic [IW-1:0] cur_eff;
    logic [IW-1:0] new_id;
    logic [HW+RW-1:0] prod;
    logic [HW-1:0] qb;

    // Reciprocal reduction: the quotient estimate is at most one too small,
    // so one subtract of the product and one correcting subtract suffice.
    assign prod = (HW+RW)'(hash_reg) * (HW+RW)'(RECIP_W);
    assign qb   = HW'(quot_reg) * BUCK_H;

    assign cur_eff = cur_from_head_reg ? head_q : cur_reg;
    assign new_id  = (freed_cnt_reg != '0) ? top_q : fresh_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= in_action;
            par_reg <= in_parent;
            sym_reg <= in_symbol;
        end
        if (cmd.hash) begin
            hash_reg  <= HW'(par_reg) * HW'(alphabet) + HW'(sym_reg);
            mstep_reg <= 2'd2;
        end
        if (cmd.modstep) begin
            case (mstep_reg)
                2'd2: quot_reg <= prod[HW+RW-1:HW];
                2'd1: hash_reg <= hash_reg - qb;
                default: begin
                    if (hash_reg >= BUCK_H) hash_reg <= hash_reg - BUCK_H;
                end
            endcase
            mstep_reg <= mstep_reg - 2'd1;
        end
        if (cmd.clr_wr)
            head_mem[clr_reg] <= '0;
        if (cmd.head_rd) begin
            head_q   <= head_mem[hash_reg[BW-1:0]];
            prev_reg <= '0;
        end
        if (cmd.rec_rd) begin
            rpar_q <= par_mem[cur_eff[NW-1:0]];
            rsym_q <= sym_mem[cur_eff[NW-1:0]];
            next_q <= link_mem[cur_eff[NW-1:0]];
        end
        if (cmd.pop_rd)
            top_q <= free_mem[freed_cnt_reg[NW-1:0] - NW'(1)];
        if (cmd.unlink) begin
            if (prev_reg != '0) link_mem[prev_reg[NW-1:0]] <= next_q;
            else                head_mem[hash_reg[BW-1:0]] <= next_q;
            if (freed_cnt_reg < IW'(MAX_NODES))
                free_mem[freed_cnt_reg[NW-1:0]] <= cur_reg;
        end
        if (cmd.create) begin
            par_mem[new_id[NW-1:0]]  <= par_reg;
            sym_mem[new_id[NW-1:0]]  <= sym_reg;
            link_mem[new_id[NW-1:0]] <= head_q;
            head_mem[hash_reg[BW-1:0]] <= new_id;
        end
        if (cmd.rec_rd) cur_reg <= cur_eff;
        if (cmd.advance) begin
            prev_reg <= cur_reg;
            cur_reg  <= next_q;
        end
        if (cmd.res_load) begin
            rs_reg <= cmd.res_status;
            if (cmd.res_status == ST_FOUND)        rc_reg <= 10'(cur_reg);
            else if (cmd.res_status == ST_CREATED) rc_reg <= 10'(new_id);
            else                                   rc_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_from_head_reg <= 1'b0;
            steps_reg <= '0;
            freed_cnt_reg <= '0;
            fresh_reg <= IW'(1);
            clr_reg <= '0;
            rv_reg <= 1'b0;
        end else begin
            if (cmd.clr_wr) clr_reg <= clr_reg + BW'(1);
            if (cmd.head_rd) begin
                cur_from_head_reg <= 1'b1;
                steps_reg <= '0;
            end
            if (cmd.rec_rd) cur_from_head_reg <= 1'b0;
            if (cmd.advance) steps_reg <= steps_reg + (IW+1)'(1);
            if (cmd.unlink && freed_cnt_reg < IW'(MAX_NODES))
                freed_cnt_reg <= freed_cnt_reg + IW'(1);
            if (cmd.create) begin
                if (freed_cnt_reg != '0) freed_cnt_reg <= freed_cnt_reg - IW'(1);
                else                     fresh_reg <= fresh_reg + IW'(1);
            end
            if (cmd.res_load)           rv_reg <= 1'b1;
            else if (res_ready)         rv_reg <= 1'b0;
        end
    end

    always_comb begin
        sts.action     = act_reg;
        sts.mod_done   = (mstep_reg == 2'd0);
        sts.cur_zero   = (cur_eff == '0) || (cur_eff >= IW'(MAX_NODES));
        sts.match      = (rpar_q == par_reg) && (rsym_q == sym_reg);
        sts.walk_over  = (steps_reg >= (IW+1)'(MAX_NODES));
        sts.free_empty = (freed_cnt_reg == '0);
        sts.fresh_out  = (fresh_reg >= IW'(MAX_NODES));
        sts.clr_last   = (clr_reg == BW'(BUCKETS - 1));
    end

    assign res_valid  = rv_reg;
    assign res_child  = rc_reg;
    assign res_status = rs_reg;

endmodule

/* rtl/hashed_trie_edge_map_core.sv */
// ----------------------------------------------------------------------------
// Hashed trie edge map core
// Chained hash table of trie edges with create, lookup and delete.
// ----------------------------------------------------------------------------
// Sequence: the item is captured and hashed, the hash is reduced modulo the
// bucket count by a quotient estimate, a subtract and a correcting subtract,
// the bucket head is read, and the chain records are read and compared in
// turn; a hit is returned or unlinked, else a create pops or takes an id.
// One item at a time: the next item waits until the result is taken.
// Reset: synchronous; a clearing pass over all BUCKETS heads empties them,
// during which no item is accepted.
module hashed_trie_edge_map_core #(
    parameter int MAX_NODES = htem_pkg::MAX_NODES_DEF,
    parameter int BUCKETS   = htem_pkg::BUCKETS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // action[1:0], parent_node[11:2], symbol[27:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // child_node[9:0], status[12:10]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import htem_pkg::*;

    logic [15:0] alpha_reg;
    cmd_t cmd;
    sts_t sts;
    logic [9:0] child;
    logic [2:0] status;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {16'd0, alpha_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn)    alpha_reg <= ALPHABET_RESET;
        else if (cfg_wr) alpha_reg <= pwdata[15:0];
    end

    htem_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .res_busy(m_tvalid), .sts(sts), .cmd(cmd)
    );

    htem_dp #(.MAX_NODES(MAX_NODES), .BUCKETS(BUCKETS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .alphabet(alpha_reg),
        .in_action(s_tdata[1:0]), .in_parent(s_tdata[11:2]),
        .in_symbol(s_tdata[27:12]), .cmd(cmd), .sts(sts),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_child(child), .res_status(status)
    );

    assign m_tdata = {3'd0, status, child};

`include "hashed_trie_edge_map_core_macros.svh"

    `HTEM_ASSERT_IMPL(a_no_accept_busy, s_tready, !m_tvalid, "item accepted while result pending")
    `HTEM_ASSERT_NEXT(a_res_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `HTEM_ASSERT_IMPL(a_status_range, m_tvalid, status <= ST_DEL_NONE, "bad status code")

endmodule

/* tb/hashed_trie_edge_map_core_tb.sv */
// ----------------------------------------------------------------------------
// Hashed trie edge map core testbench
// Drives lookup, create and delete items through the stream ports and sets
// the alphabet size over the APB port between phases. Each result is
// compared with a model of the chained hash table or with a typed value.
// ----------------------------------------------------------------------------
module hashed_trie_edge_map_core_tb;
    import htem_pkg::*;

    localparam int NODES = MAX_NODES_DEF;
    localparam int NBKT = BUCKETS_DEF;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [1:0] ADDR_ALPHABET = 2'd0;
    localparam int IDLE_LIMIT = 40000;

    typedef struct {
        logic [1:0]  action;
        logic [9:0]  parent;
        logic [15:0] symbol;
        bit          known;
        logic [9:0]  child;
        logic [2:0]  status;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // action[1:0], parent_node[11:2], symbol[27:12]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // child_node[9:0], status[12:10]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model of the edge table.
    logic [15:0] alpha;
    logic [10:0] bkt_head [NBKT];
    logic [9:0]  rec_parent [NODES];
    logic [15:0] rec_symbol [NODES];
    logic [10:0] rec_link [NODES];
    logic [9:0]  free_stack [NODES];
    int          free_depth;
    int          next_fresh;
    logic [25:0] live_keys [$];

    logic [12:0] result_q [$];   // {status, child}
    dir_row_t    dir_tab [20];
    int          fail_cnt = 0;
    int          n_sent = 0;
    int          burst_left = 0;
    int          full_seen = 0;
    int          idle_cycles = 0;
    int          stall_cnt = 0;
    bit          long_stall_done = 0;
    bit          steady_rx = 0;

    hashed_trie_edge_map_core u_dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [12:0] edge_map_step(logic [1:0] act, logic [9:0] par,
                                                  logic [15:0] sym);
        longint unsigned h;
        int b, cur, prev, hit, steps, id, k;
        logic [9:0] child;
        logic [2:0] st;
        h = longint'(par) * longint'(alpha) + longint'(sym);
        b = int'(h % NBKT);
        cur = bkt_head[b];
        prev = 0;
        hit = 0;
        steps = 0;
        while (cur != 0 && cur < NODES && steps < NODES) begin
            if (rec_parent[cur] == par && rec_symbol[cur] == sym) begin
                hit = cur;
                break;
            end
            prev = cur;
            cur = rec_link[cur];
            steps++;
        end
        child = '0;
        if (act == ACT_DELETE) begin
            if (hit == 0) begin
                st = ST_DEL_NONE;
            end else begin
                if (prev != 0) rec_link[prev] = rec_link[hit];
                else bkt_head[b] = rec_link[hit];
                if (free_depth < NODES) begin
                    free_stack[free_depth] = hit[9:0];
                    free_depth++;
                end
                st = ST_DELETED;
                for (k = 0; k < live_keys.size(); k++)
                    if (live_keys[k] == {par, sym}) begin
                        live_keys.delete(k);
                        break;
                    end
            end
        end else if (hit != 0) begin
            child = hit[9:0];
            st = ST_FOUND;
        end else if (act != ACT_CREATE) begin
            st = ST_ABSENT;
        end else if (free_depth == 0 && next_fresh >= NODES) begin
            st = ST_FULL;
        end else begin
            if (free_depth != 0) begin
                free_depth--;
                id = free_stack[free_depth];
            end else begin
                id = next_fresh;
                next_fresh++;
            end
            rec_parent[id] = par;
            rec_symbol[id] = sym;
            rec_link[id] = bkt_head[b];
            bkt_head[b] = id[10:0];
            child = id[9:0];
            st = ST_CREATED;
            live_keys.push_back({par, sym});
        end
        return {st, child};
    endfunction

    task automatic send_item(logic [1:0] act, logic [9:0] par, logic [15:0] sym,
                             bit known = 0, logic [12:0] typed = '0);
        logic [12:0] predicted;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, sym, par, act};
        do @(posedge aclk); while (!s_tready);
        predicted = edge_map_step(act, par, sym);
        result_q.push_back(known ? typed : predicted);
        if (predicted[12:10] == ST_FULL) full_seen++;
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_alphabet(logic [15:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_ALPHABET;
        pwdata <= {16'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        alpha = value;
        @(posedge aclk);
        if (prdata[15:0] !== value || pready !== 1'b1) begin
            $display("%0t: alphabet readback expected %0d actual %0d",
                     $time, value, prdata[15:0]);
            fail_cnt++;
        end
    endtask

    // Lookups and deletes mostly reuse live keys, so hits, chain walks and
    // deletes of live edges are common; the other keys are random.
    task automatic random_item(int create_pct);
        logic [1:0] act;
        logic [25:0] key;
        int r;
        r = $urandom_range(0, 99);
        if (r < create_pct) act = ACT_CREATE;
        else if (r < create_pct + (100 - create_pct) / 2)
            act = ($urandom_range(0, 4) == 0) ? ACT_SPARE : ACT_LOOKUP;
        else act = ACT_DELETE;
        if (live_keys.size() != 0 && $urandom_range(0, 99) < (act == ACT_CREATE ? 25 : 65))
            key = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else if ($urandom_range(0, 1) == 0)
            key = {10'($urandom_range(0, 15)), 16'($urandom_range(0, 40))};
        else
            key = 26'($urandom);
        send_item(act, key[25:16], key[15:0]);
    endtask

    always @(posedge aclk) begin
        if (stall_cnt > 0) begin
            m_tready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end else if (n_sent >= 300 && !long_stall_done) begin
            // One long hold-off while the sender keeps offering items.
            m_tready <= 1'b0;
            stall_cnt <= 400;
            long_stall_done <= 1'b1;
        end else begin
            if ($urandom_range(0, 63) == 0) steady_rx <= ~steady_rx;
            m_tready <= steady_rx ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        logic [12:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_tdata);
                fail_cnt++;
            end else begin
                want = result_q.pop_front();
                if (m_tdata[9:0] !== want[9:0]) begin
                    $display("%0t: child_node expected %0d actual %0d",
                             $time, want[9:0], m_tdata[9:0]);
                    fail_cnt++;
                end
                if (m_tdata[12:10] !== want[12:10]) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want[12:10], m_tdata[12:10]);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (!s_tvalid && result_q.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("FAIL hashed_trie_edge_map_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        alpha = ALPHABET_RESET;
        foreach (bkt_head[i]) bkt_head[i] = '0;
        free_depth = 0;
        next_fresh = 1;
        // Symbols 10, 1374 and 2738 under parent 0 share one bucket at the
        // reset alphabet, which exercises head and tail unlinking.
        dir_tab = '{
            '{ACT_LOOKUP, 10'd0, 16'd0, 1, 10'd0, ST_ABSENT},
            '{ACT_CREATE, 10'd0, 16'd0, 1, 10'd1, ST_CREATED},
            '{ACT_CREATE, 10'd1023, 16'd65535, 1, 10'd2, ST_CREATED},
            '{ACT_LOOKUP, 10'd0, 16'd0, 1, 10'd1, ST_FOUND},
            '{ACT_SPARE, 10'd1023, 16'd65535, 1, 10'd2, ST_FOUND},
            '{ACT_CREATE, 10'd0, 16'd0, 1, 10'd1, ST_FOUND},
            '{ACT_DELETE, 10'd0, 16'd0, 1, 10'd0, ST_DELETED},
            '{ACT_DELETE, 10'd0, 16'd0, 1, 10'd0, ST_DEL_NONE},
            '{ACT_LOOKUP, 10'd0, 16'd0, 1, 10'd0, ST_ABSENT},
            '{ACT_CREATE, 10'd7, 16'd10, 1, 10'd1, ST_CREATED},
            '{ACT_CREATE, 10'd0, 16'd10, 0, 10'd0, ST_FOUND},
            '{ACT_CREATE, 10'd0, 16'd1374, 0, 10'd0, ST_FOUND},
            '{ACT_CREATE, 10'd0, 16'd2738, 0, 10'd0, ST_FOUND},
            '{ACT_DELETE, 10'd0, 16'd2738, 0, 10'd0, ST_FOUND},
            '{ACT_LOOKUP, 10'd0, 16'd10, 0, 10'd0, ST_FOUND},
            '{ACT_LOOKUP, 10'd0, 16'd1374, 0, 10'd0, ST_FOUND},
            '{ACT_DELETE, 10'd0, 16'd10, 0, 10'd0, ST_FOUND},
            '{ACT_LOOKUP, 10'd0, 16'd1374, 0, 10'd0, ST_FOUND},
            '{ACT_SPARE, 10'd512, 16'd32768, 1, 10'd0, ST_ABSENT},
            '{ACT_DELETE, 10'd1023, 16'd65535, 1, 10'd0, ST_DELETED}
        };
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i])
            send_item(dir_tab[i].action, dir_tab[i].parent, dir_tab[i].symbol,
                      dir_tab[i].known, {dir_tab[i].status, dir_tab[i].child});
        drain();

        set_alphabet(16'd1);
        repeat (100) random_item(40);
        drain();
        set_alphabet(16'd65535);
        repeat (100) random_item(40);
        drain();
        set_alphabet(16'd0);
        repeat (80) random_item(40);
        drain();
        set_alphabet(16'd1364);
        repeat (80) random_item(40);
        drain();

        // Fill the table until creates report full, then free some ids.
        set_alphabet(ALPHABET_RESET);
        while (full_seen < 4 && n_sent < 2200)
            send_item(ACT_CREATE, 10'($urandom), 16'($urandom));
        repeat (120) random_item(30);
        drain();

        if (fail_cnt == 0) begin
            $display("PASS hashed_trie_edge_map_core");
        end else begin
            $display("FAIL hashed_trie_edge_map_core");
        end
        $finish;
    end
endmodule
